>>> src/sdes_pkg.sv
// constants and codes shared by the servo drive enable sequencer
// no dependencies
package sdes_pkg;

  // sequence step codes
  localparam logic [2:0] STEP_SHUTDOWN = 3'd0;
  localparam logic [2:0] STEP_MODE_SEL = 3'd1;
  localparam logic [2:0] STEP_ALIGN    = 3'd2;
  localparam logic [2:0] STEP_SWITCHON = 3'd3;
  localparam logic [2:0] STEP_ENABLE   = 3'd4;
  localparam logic [2:0] STEP_RUN      = 3'd5;

  // control words
  localparam logic [15:0] CW_SHUTDOWN   = 16'h0006;
  localparam logic [15:0] CW_SWITCH_ON  = 16'h0007;
  localparam logic [15:0] CW_ENABLE_OP  = 16'h000F;
  localparam logic [15:0] CW_HOME_START = 16'h001F;

  // status word codes
  localparam logic [7:0]  SW_READY      = 8'h31;
  localparam logic [7:0]  SW_SWITCHED   = 8'h33;
  localparam logic [7:0]  SW_OP_ENABLED = 8'h37;
  localparam logic [7:0]  SW_HOME_BUSY  = 8'h06;
  localparam logic [7:0]  SW_HOME_DONE  = 8'h16;

  // operation modes
  localparam logic signed [7:0] MODE_HOME = 8'sd6;
  localparam logic signed [7:0] MODE_CSP  = 8'sd8;

  // configuration register indexes
  localparam logic CFG_SETTLE_WINDOW = 1'b0;
  localparam logic CFG_START_WINDOW  = 1'b1;

  localparam logic [15:0] SETTLE_RESET = 16'd100;
  localparam logic [19:0] START_RESET  = 20'd3000;

endpackage

>>> src/servo_drive_enable_sequencer.sv
// servo drive enable sequencer, top level
// depends on sdes_pkg
//
// per-axis cia 402 enable sequencer. each input request is one process-data
// cycle of one axis: axis, status word, displayed mode, actual and commanded
// position on s_tdata, the mode selector (0 csp, 1 homing) on s_tuser.
// each request gives exactly one result request on m_tdata: control word,
// operation mode and target position to send, plus enabled, homing_done
// and the current sequence step.
// a request reaches m_tvalid through the input register, then the sequencing
// logic into the output register. one request per cycle is accepted while
// s_tready is high; the per-axis state is written on the same edge the
// result is registered, so back-to-back requests to one axis need no bypass.
// when the receiver stalls, the output register holds and the input register
// keeps taking one more request; s_tready falls only when both are full.
// reset (rst, synchronous) empties both registers, clears every axis to the
// shutdown step with zero held values and loads the windows to 100 and 3000.
// cfg_write/cfg_index/cfg_data write settle_window (0) or start_window (1);
// write only while idle.
// an axis index at or above AXES changes nothing and returns all zeros.
module servo_drive_enable_sequencer
  import sdes_pkg::*;
#(
  parameter int AXES = 6
) (
  input  logic        clk,
  input  logic        rst,
  // axis[2:0], status[18:3], mode_display[26:19],
  // actual_position[58:27], commanded_position[90:59], zero fill
  input  logic [95:0] s_tdata,
  // mode
  input  logic        s_tuser,
  input  logic        s_tvalid,
  output logic        s_tready,
  // control_word[15:0], opmode[23:16], target_position[55:24],
  // enabled[56], homing_done[57], sequence_step[60:58], zero fill
  output logic [63:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  // index width for the per-axis state
  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam logic [3:0] AXES_LIM = 4'(AXES);

  // configuration
  logic [15:0] settle_window;
  logic [19:0] start_window;

  // per-axis state
  logic [2:0]  axis_step    [AXES];
  logic [15:0] axis_control [AXES];
  logic [7:0]  axis_mode    [AXES];
  logic [31:0] axis_target  [AXES];

  // input register
  logic               in_valid;
  logic [2:0]         in_axis;
  logic               in_homing;
  logic [15:0]        in_status;
  logic signed [7:0]  in_disp;
  logic signed [31:0] in_actual;
  logic signed [31:0] in_cmd;

  // output register
  logic        out_valid;
  logic [63:0] out_data;

  logic advance;
  logic fire;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign fire     = in_valid && advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // sequencing logic on the registered request
  logic              ax_ok;
  logic [AXW-1:0]    a;
  logic [2:0]        step_cur;
  logic [2:0]        step_next;
  logic [15:0]       control_next;
  logic [7:0]        mode_next;
  logic [31:0]       target_next;
  logic              done;
  logic [7:0]        st_lo;
  logic [7:0]        st_hi;
  logic signed [33:0] settle_diff;
  logic signed [33:0] start_diff;
  logic signed [33:0] settle_lim;
  logic signed [33:0] start_lim;
  logic              settle_ok;
  logic              start_ok;
  logic [63:0]       result;

  always_comb begin
    ax_ok    = {1'b0, in_axis} < AXES_LIM;
    a        = in_axis[AXW-1:0];
    step_cur = axis_step[a];
    st_lo    = in_status[7:0];
    st_hi    = in_status[15:8];

    // windows compared at full width, no wrap
    settle_diff = 34'($signed(axis_target[a])) - 34'(in_actual);
    start_diff  = 34'(in_cmd) - 34'(in_actual);
    settle_lim  = $signed({18'd0, settle_window});
    start_lim   = $signed({14'd0, start_window});
    settle_ok   = (settle_diff > -settle_lim) && (settle_diff < settle_lim);
    start_ok    = (start_diff > -start_lim) && (start_diff < start_lim);

    step_next    = step_cur;
    control_next = axis_control[a];
    mode_next    = axis_mode[a];
    target_next  = axis_target[a];
    done         = 1'b0;

    if (in_homing) begin
      if (in_disp == MODE_HOME && st_lo == SW_OP_ENABLED) begin
        if (st_hi == SW_HOME_BUSY) begin
          control_next = CW_HOME_START;
        end else if (st_hi == SW_HOME_DONE) begin
          control_next = CW_SWITCH_ON;
          done         = 1'b1;
        end
      end else begin
        mode_next    = MODE_HOME;
        control_next = CW_ENABLE_OP;
      end
    end else if (step_cur >= STEP_RUN) begin
      target_next = in_cmd;
    end else begin
      unique case (step_cur)
        STEP_SHUTDOWN: begin
          control_next = CW_SHUTDOWN;
          if (st_lo == SW_READY) step_next = STEP_MODE_SEL;
        end
        STEP_MODE_SEL: begin
          mode_next = MODE_CSP;
          if (in_disp == MODE_CSP) step_next = STEP_ALIGN;
        end
        STEP_ALIGN: begin
          // settle check uses the target held before this write
          target_next = in_actual;
          if (settle_ok && start_ok) step_next = STEP_SWITCHON;
        end
        STEP_SWITCHON: begin
          control_next = CW_SWITCH_ON;
          if (st_lo == SW_SWITCHED) step_next = STEP_ENABLE;
        end
        default: begin
          control_next = CW_ENABLE_OP;
          if (st_lo == SW_OP_ENABLED) step_next = STEP_RUN;
        end
      endcase
    end

    if (ax_ok) begin
      result = {3'd0, step_next, done, (step_next >= STEP_RUN),
                target_next, mode_next, control_next};
    end else begin
      result = '0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_window <= SETTLE_RESET;
      start_window  <= START_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SETTLE_WINDOW: settle_window <= cfg_data[15:0];
        CFG_START_WINDOW:  start_window  <= cfg_data;
        default:           ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_axis   <= s_tdata[2:0];
      in_homing <= s_tuser;
      in_status <= s_tdata[18:3];
      in_disp   <= $signed(s_tdata[26:19]);
      in_actual <= $signed(s_tdata[58:27]);
      in_cmd    <= $signed(s_tdata[90:59]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

  // per-axis state, written when a request moves to the output
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        axis_step[i]    <= STEP_SHUTDOWN;
        axis_control[i] <= '0;
        axis_mode[i]    <= '0;
        axis_target[i]  <= '0;
      end
    end else if (fire && ax_ok) begin
      axis_step[a]    <= step_next;
      axis_control[a] <= control_next;
      axis_mode[a]    <= mode_next;
      axis_target[a]  <= target_next;
    end
  end

`ifndef ASSERT_OFF
  // enabled flag follows the reported step
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[56] == (m_tdata[60:58] >= STEP_RUN)))
    else $error("enabled flag disagrees with step");

  // homing completion always leaves the switch-on control word
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[57]) |-> (m_tdata[15:0] == CW_SWITCH_ON))
    else $error("homing done without switch-on control");

  // step code never runs past the running step
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[60:58] <= STEP_RUN))
    else $error("step code out of range");

  // a stalled result stays put while the input side keeps filling
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // nothing comes out right after reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");
`endif

endmodule
